// File: design/rrwsack_pkg.sv
// Shared types, codes and defaults for the selective-ack receive window.
package rrwsack_pkg;

	localparam int WINDOW_SLOTS_DEF = 32;
	localparam int SEQ_BITS_DEF     = 16;
	localparam int MAX_BLOCKS       = 16;
	localparam int CREDIT_W         = 21;
	localparam int OFS_W            = 9;
	localparam logic [CREDIT_W-1:0] CREDIT_RESET = 21'd65536;

	localparam logic [2:0] ST_STORED    = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_BEYOND    = 3'd2;
	localparam logic [2:0] ST_CONFLICT  = 3'd3;
	localparam logic [2:0] ST_NO_CREDIT = 3'd4;
	localparam logic [2:0] ST_DISPATCH  = 3'd5;
	localparam logic [2:0] ST_NOTHING   = 3'd6;

	localparam logic MODE_ADD  = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [15:0] seq;
		logic [15:0] size;
	} in_item_t;

	typedef struct packed {
		logic [2:0]          status;
		logic                accepted;
		logic                ack_valid;
		logic [15:0]         cumulative_ack;
		logic [CREDIT_W-1:0] credit_left;
		logic                gap_valid;
		logic [OFS_W-1:0]    gap_start;
		logic [OFS_W-1:0]    gap_end;
		logic [15:0]         read_seq;
		logic [15:0]         read_size;
		logic [7:0]          read_slot;
		logic                last;
	} result_t;

endpackage

// File: design/rrwsack_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrwsack_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// File: design/reliable_receive_window_sack.sv
// Top level: selective-ack receive window with an iterative slot scanner.
// A read item goes through S_RD_CHK, then S_RD_OUT loads its one result into the output register;
// the next item is taken once that result is pushed. An add item goes through S_ADD_CHK, the
// ack walk (S_ACK), the gap walk (S_GAP, only once an ack exists) and S_FIN, which loads its
// last result; the next item is taken once that result is pushed.
// One item at a time; the single slot walker sets the rate, and output stalls hold the gap walk and final result.
// Reset (arst_n low, asynchronous): all slots empty, sequence marks at minus one, no ack,
// no used credit, credit register 65536. Slot contents are not cleared.
module reliable_receive_window_sack #(
	parameter int WINDOW_SLOTS = rrwsack_pkg::WINDOW_SLOTS_DEF, // power of two, 2..256
	parameter int SEQ_BITS     = rrwsack_pkg::SEQ_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 window_credit_we,
	input  logic [rrwsack_pkg::CREDIT_W-1:0]     window_credit_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  rrwsack_pkg::in_item_t                in_item,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output rrwsack_pkg::result_t                 out_item
);
	import rrwsack_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_SLOTS);
	localparam int K_W   = $clog2(WINDOW_SLOTS + 1);
	localparam int NB_W  = $clog2(MAX_BLOCKS + 1);
	localparam int RAM_W = SEQ_BITS + 16;
	localparam logic [SEQ_BITS-1:0] SEQ_ONES = {SEQ_BITS{1'b1}};

	typedef enum logic [2:0] {
		S_IDLE, S_ADD_CHK, S_ACK, S_GAP, S_FIN, S_RD_CHK, S_RD_OUT
	} state_t;

	// Serial-number compare: a is after b when the forward distance lies in the lower half.
	function automatic logic seq_gt(input logic [SEQ_BITS-1:0] a, input logic [SEQ_BITS-1:0] b);
		logic [SEQ_BITS-1:0] d;
		d = a - b;
		return (d != '0) && !d[SEQ_BITS-1];
	endfunction

	state_t                   state_q;
	logic [WINDOW_SLOTS-1:0]  full_q;
	logic [SEQ_BITS-1:0]      newest_q, disp_q, cum_q, i_q, s_q;
	logic                     seen_q;
	logic [CREDIT_W-1:0]      used_q, credit_q;
	logic [15:0]              sz_q;
	logic [2:0]               status_q;
	logic [K_W-1:0]           k_q;
	logic                     open_q, have_pend_q;
	logic [OFS_W-1:0]         start_q, pend_s_q, pend_e_q;
	logic [NB_W-1:0]          nblk_q;
	logic [15:0]              rseq_q, rsize_q;
	logic [7:0]               rslot_q;
	logic                     out_valid_q;
	result_t                  out_q;

	logic                     in_acc, can_push, push, push_last, push_gap;
	result_t                  push_d;
	logic [31:0]              seq_wide, cum_wide, rnxt_wide, ofs_s_wide, ofs_e_wide;
	logic [SEQ_BITS-1:0]      seq_in, nxt_disp, ofs_s, ofs_e, i_next;
	logic [IDX_W-1:0]         rd_addr, s_idx, i_idx, nxt_idx;
	logic [RAM_W-1:0]         rd_data, wr_data;
	logic [SEQ_BITS-1:0]      rd_seq;
	logic [15:0]              rd_size;
	logic                     wr_en;
	logic [CREDIT_W:0]        need_sum, sat_sum;
	logic                     credit_ok;
	logic [2:0]               add_status;
	logic                     ack_step, gap_end, gap_close, rd_hit;
	logic [CREDIT_W-1:0]      credit_now;

	// Resize the fixed 16-bit sequence field to the sequence width and back.
	assign seq_wide = 32'(in_item.seq);
	assign seq_in   = seq_wide[SEQ_BITS-1:0];
	assign cum_wide = 32'(cum_q);
	assign nxt_disp = disp_q + 1'b1;
	assign rnxt_wide = 32'(nxt_disp);
	assign s_idx    = s_q[IDX_W-1:0];
	assign i_idx    = i_q[IDX_W-1:0];
	assign nxt_idx  = nxt_disp[IDX_W-1:0];
	assign i_next   = i_q + 1'b1;

	// Offsets of the current walk position from the cumulative ack.
	assign ofs_s      = i_q - cum_q;
	assign ofs_e      = i_q - 1'b1 - cum_q;
	assign ofs_s_wide = 32'(ofs_s);
	assign ofs_e_wide = 32'(ofs_e);

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign can_push = !out_valid_q || !out_stall;

	// Slot sequence and size share one RAM word; look up at acceptance, use next cycle.
	assign rd_addr = (in_item.mode == MODE_READ) ? nxt_idx : seq_in[IDX_W-1:0];
	assign rd_seq  = rd_data[RAM_W-1:16];
	assign rd_size = rd_data[15:0];
	assign wr_data = {s_q, sz_q};

	rrwsack_ram #(.WIDTH(RAM_W), .DEPTH(WINDOW_SLOTS)) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (s_idx),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Admission check for an add.
	always_comb begin
		need_sum   = {1'b0, used_q} + (CREDIT_W+1)'(sz_q);
		sat_sum    = need_sum[CREDIT_W] ? {1'b0, {CREDIT_W{1'b1}}} : need_sum;
		credit_ok  = seq_gt(newest_q, s_q) || (need_sum <= {1'b0, credit_q});
		add_status = ST_DUPLICATE;
		if (!credit_ok) begin
			add_status = ST_NO_CREDIT;
		end else if (seq_gt(s_q, disp_q + SEQ_BITS'(WINDOW_SLOTS))) begin
			add_status = ST_BEYOND;
		end else if (seq_gt(s_q, disp_q)) begin
			if (!full_q[s_idx]) begin
				add_status = ST_STORED;
			end else if (rd_seq != s_q) begin
				add_status = ST_CONFLICT;
			end
		end
		wr_en = (state_q == S_ADD_CHK) && (add_status == ST_STORED);
	end

	// Walk decisions and result assembly.
	always_comb begin
		ack_step  = (k_q != K_W'(WINDOW_SLOTS)) && !seq_gt(i_q, newest_q) && full_q[i_idx];
		gap_end   = (k_q == K_W'(WINDOW_SLOTS)) || seq_gt(i_q, newest_q);
		gap_close = open_q && (nblk_q < NB_W'(MAX_BLOCKS)) && (gap_end || !full_q[i_idx]);
		rd_hit    = full_q[nxt_idx] && (rd_seq == nxt_disp);
		credit_now = (credit_q > used_q) ? credit_q - used_q : '0;

		push      = 1'b0;
		push_last = 1'b0;
		push_gap  = 1'b0;
		case (state_q)
			S_GAP: begin
				push = can_push && gap_close && have_pend_q;
				push_gap = 1'b1;
			end
			S_FIN: begin
				push      = can_push;
				push_last = 1'b1;
				push_gap  = have_pend_q;
			end
			S_RD_OUT: begin
				push      = can_push;
				push_last = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase

		push_d.status         = status_q;
		push_d.accepted       = (status_q == ST_STORED) || (status_q == ST_DUPLICATE);
		push_d.ack_valid      = seen_q;
		push_d.cumulative_ack = cum_wide[15:0];
		push_d.credit_left    = credit_now;
		push_d.gap_valid      = push_gap;
		push_d.gap_start      = push_gap ? pend_s_q : '0;
		push_d.gap_end        = push_gap ? pend_e_q : '0;
		push_d.read_seq       = rseq_q;
		push_d.read_size      = rsize_q;
		push_d.read_slot      = rslot_q;
		push_d.last           = push_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			full_q      <= '0;
			newest_q    <= SEQ_ONES;
			disp_q      <= SEQ_ONES;
			cum_q       <= SEQ_ONES;
			seen_q      <= 1'b0;
			used_q      <= '0;
			credit_q    <= CREDIT_RESET;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			open_q      <= 1'b0;
			have_pend_q <= 1'b0;
			nblk_q      <= '0;
		end else begin
			if (window_credit_we) begin
				credit_q <= window_credit_wdata;
			end

			// Output register: load on push, drop once taken.
			if (push) begin
				out_q       <= push_d;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						s_q     <= seq_in;
						sz_q    <= in_item.size;
						rseq_q  <= '0;
						rsize_q <= '0;
						rslot_q <= '0;
						state_q <= (in_item.mode == MODE_READ) ? S_RD_CHK : S_ADD_CHK;
					end
				end
				S_ADD_CHK: begin
					status_q <= add_status;
					if (add_status == ST_STORED) begin
						full_q[s_idx] <= 1'b1;
						used_q        <= sat_sum[CREDIT_W-1:0];
						if (seq_gt(s_q, newest_q)) begin
							newest_q <= s_q;
						end
					end
					i_q     <= (seq_gt(cum_q, disp_q) ? cum_q : disp_q) + 1'b1;
					k_q     <= '0;
					state_q <= S_ACK;
				end
				S_ACK: begin
					// Advance the cumulative ack over consecutive full slots.
					if (ack_step) begin
						cum_q  <= i_q;
						seen_q <= 1'b1;
						i_q    <= i_next;
						k_q    <= k_q + 1'b1;
					end else begin
						i_q         <= cum_q + 1'b1;
						k_q         <= '0;
						open_q      <= 1'b0;
						have_pend_q <= 1'b0;
						nblk_q      <= '0;
						state_q     <= seen_q ? S_GAP : S_FIN;
					end
				end
				S_GAP: begin
					// Hold one finished block back so the final one can carry last.
					if (can_push) begin
						if (gap_close) begin
							pend_s_q    <= start_q;
							pend_e_q    <= ofs_e_wide[OFS_W-1:0];
							have_pend_q <= 1'b1;
							nblk_q      <= nblk_q + 1'b1;
						end
						if (gap_end) begin
							state_q <= S_FIN;
						end else begin
							if (full_q[i_idx]) begin
								if (!open_q) begin
									open_q  <= 1'b1;
									start_q <= ofs_s_wide[OFS_W-1:0];
								end
							end else begin
								open_q <= 1'b0;
							end
							i_q <= i_next;
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_FIN: begin
					if (can_push) begin
						state_q <= S_IDLE;
					end
				end
				S_RD_CHK: begin
					if (rd_hit) begin
						status_q       <= ST_DISPATCH;
						full_q[nxt_idx] <= 1'b0;
						disp_q         <= nxt_disp;
						used_q         <= (used_q > CREDIT_W'(rd_size)) ?
							used_q - CREDIT_W'(rd_size) : '0;
						rseq_q         <= rnxt_wide[15:0];
						rsize_q        <= rd_size;
						rslot_q        <= 8'(nxt_idx);
					end else begin
						status_q <= ST_NOTHING;
					end
					state_q <= S_RD_OUT;
				end
				S_RD_OUT: begin
					if (can_push) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;
endmodule

// File: design/rrwsack_chk.sv
// Port-level assertions for the receive window, bound to the top level.
module rrwsack_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input rrwsack_pkg::result_t out_item
);
	import rrwsack_pkg::*;

	a_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.accepted ==
			((out_item.status == ST_STORED) || (out_item.status == ST_DUPLICATE))))
		else $error("accepted flag disagrees with status");

	a_read_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((out_item.status == ST_DISPATCH) || (out_item.status == ST_NOTHING))
		|-> out_item.last && !out_item.gap_valid)
		else $error("read result must be a single result without a block");

	a_gap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.gap_valid |-> (out_item.gap_start == '0) && (out_item.gap_end == '0))
		else $error("block offsets set without a block");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("new transaction taken while one is in work");
endmodule

bind reliable_receive_window_sack rrwsack_chk u_rrwsack_chk (.*);

// File: verif/rrwsack_checker.sv
// Checker: predicts receive-window results and compares them with the block's output.
`timescale 1ns / 1ps
module rrwsack_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             window_credit_we,
	input  logic [rrwsack_pkg::CREDIT_W-1:0] window_credit_wdata,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  rrwsack_pkg::in_item_t            in_item,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  rrwsack_pkg::result_t             out_item,
	output int                               fail_count,
	output int                               pending
);
	import rrwsack_pkg::*;

	localparam int SLOTS = WINDOW_SLOTS_DEF;

	logic        occupied [SLOTS];
	logic [15:0] held_seq [SLOTS];
	logic [15:0] held_size [SLOTS];
	logic [15:0] newest, dispatched, cum_ack;
	logic        cum_seen;
	logic [CREDIT_W-1:0] used, credit;
	result_t     expected_results [$];

	function automatic logic serial_after(logic [15:0] a, logic [15:0] b);
		logic [15:0] d;
		d = a - b;
		return d != 0 && d < 16'h8000;
	endfunction

	function automatic logic [CREDIT_W-1:0] headroom();
		return credit > used ? credit - used : '0;
	endfunction

	function automatic result_t make_result(logic [2:0] st);
		result_t r;
		r = '0;
		r.status = st;
		r.accepted = (st == ST_STORED || st == ST_DUPLICATE);
		r.ack_valid = cum_seen;
		r.cumulative_ack = cum_ack;
		r.credit_left = headroom();
		r.last = 1'b1;
		return r;
	endfunction

	task automatic predict_window(input in_item_t it);
		logic [2:0]  st;
		logic [15:0] s, i, first;
		logic [4:0]  idx;
		logic        open;
		int          n;
		logic [21:0] sum;
		result_t     r;
		result_t     blocks [$];
		if (it.mode == MODE_READ) begin
			i = dispatched + 1;
			idx = i[4:0];
			if (occupied[idx] && held_seq[idx] == i) begin
				occupied[idx] = 1'b0;
				dispatched = i;
				used = used > held_size[idx] ? used - held_size[idx] : '0;
				r = make_result(ST_DISPATCH);
				r.read_seq = i;
				r.read_size = held_size[idx];
				r.read_slot = 8'(idx);
			end else begin
				r = make_result(ST_NOTHING);
			end
			expected_results.push_back(r);
			return;
		end
		s = it.seq;
		idx = s[4:0];
		sum = it.size + used;
		if (serial_after(newest, s) || sum <= credit) begin
			if (serial_after(s, dispatched + 16'(SLOTS))) st = ST_BEYOND;
			else if (serial_after(s, dispatched)) begin
				if (!occupied[idx]) begin
					sum = used + it.size;
					used = sum > 22'h1FFFFF ? 21'h1FFFFF : sum[20:0];
					occupied[idx] = 1'b1;
					held_seq[idx] = s;
					held_size[idx] = it.size;
					if (serial_after(s, newest)) newest = s;
					st = ST_STORED;
				end else if (held_seq[idx] != s) st = ST_CONFLICT;
				else st = ST_DUPLICATE;
			end else st = ST_DUPLICATE;
		end else st = ST_NO_CREDIT;
		// advance the cumulative ack over consecutive full slots
		i = (serial_after(cum_ack, dispatched) ? cum_ack : dispatched) + 1;
		for (int k = 0; k < SLOTS; k++) begin
			if (serial_after(i, newest) || !occupied[i[4:0]]) break;
			cum_ack = i;
			cum_seen = 1'b1;
			i++;
		end
		n = 0;
		open = 1'b0;
		first = '0;
		if (cum_seen) begin
			i = cum_ack + 1;
			for (int k = 0; k < SLOTS; k++) begin
				if (serial_after(i, newest)) break;
				if (occupied[i[4:0]]) begin
					if (!open) begin
						open = 1'b1;
						first = i - cum_ack;
					end
				end else if (open) begin
					if (n < MAX_BLOCKS) begin
						r = make_result(st);
						r.gap_valid = 1'b1;
						r.gap_start = first[8:0];
						r.gap_end = 9'(16'(i - 1 - cum_ack));
						blocks.push_back(r);
						n++;
					end
					open = 1'b0;
				end
				i++;
			end
			if (open && n < MAX_BLOCKS) begin
				r = make_result(st);
				r.gap_valid = 1'b1;
				r.gap_start = first[8:0];
				r.gap_end = 9'(16'(i - 1 - cum_ack));
				blocks.push_back(r);
				n++;
			end
		end
		if (n == 0) expected_results.push_back(make_result(st));
		else begin
			foreach (blocks[k]) begin
				r = blocks[k];
				r.last = (k == n - 1);
				expected_results.push_back(r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int k = 0; k < SLOTS; k++) occupied[k] = 1'b0;
			newest = 16'hFFFF;
			dispatched = 16'hFFFF;
			cum_ack = 16'hFFFF;
			cum_seen = 1'b0;
			used = '0;
			credit = CREDIT_RESET;
			expected_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (window_credit_we) credit = window_credit_wdata;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_item);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (want.status != out_item.status ||
					    want.accepted != out_item.accepted ||
					    want.ack_valid != out_item.ack_valid ||
					    want.cumulative_ack != out_item.cumulative_ack ||
					    want.credit_left != out_item.credit_left ||
					    want.gap_valid != out_item.gap_valid ||
					    want.gap_start != out_item.gap_start ||
					    want.gap_end != out_item.gap_end ||
					    want.read_seq != out_item.read_seq ||
					    want.read_size != out_item.read_size ||
					    want.read_slot != out_item.read_slot ||
					    want.last != out_item.last) begin
						$display("%0t: expected %p actual %p", $time, want, out_item);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) predict_window(in_item);
			pending = expected_results.size();
		end
	end
endmodule

// File: verif/tb.sv
// Testbench top: drives transactions into the receive window and reports the verdict.
`timescale 1ns / 1ps
module tb;
	import rrwsack_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                window_credit_we;
	logic [CREDIT_W-1:0] window_credit_wdata;
	logic                in_valid;
	logic                in_stall;
	in_item_t            in_item;
	logic                out_valid;
	logic                out_stall;
	result_t             out_item;
	int                  fail_count;
	int                  pending;
	int                  hold_off;     // long receiver hold-off, in cycles
	logic [15:0]         base_seq;     // tracks the sender's rough in-order position

	reliable_receive_window_sack dut (
		.clk(clk), .arst_n(arst_n),
		.window_credit_we(window_credit_we), .window_credit_wdata(window_credit_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	rrwsack_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.window_credit_we(window_credit_we), .window_credit_wdata(window_credit_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop: generous beyond the slowest legal run.
	initial begin
		#60ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: random stall pattern, with quiet stretches and long hold-offs on request.
	initial begin
		out_stall = 1'b0;
		hold_off = 0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_stall = 1'b1;
				hold_off--;
			end else if ($urandom_range(0, 3) == 0) out_stall = ($urandom_range(0, 1) == 0);
			else out_stall = 1'b0;
		end
	end

	// Offer one transaction and hold it until accepted; gaps come from a random pause after some items.
	task automatic send_item(input logic m, input logic [15:0] s, input logic [15:0] z);
		in_valid <= 1'b1;
		in_item <= '{mode: m, seq: s, size: z};
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if ($urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic drain_and_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (2 * WINDOW_SLOTS_DEF + 20) @(negedge clk);
	endtask

	task automatic write_credit(input logic [CREDIT_W-1:0] v);
		window_credit_we <= 1'b1;
		window_credit_wdata <= v;
		@(negedge clk);
		window_credit_we <= 1'b0;
	endtask

	task automatic random_phase(input int count);
		logic [15:0] s;
		logic [15:0] z;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 2) == 0) send_item(MODE_READ, 16'($urandom), 16'($urandom));
			else begin
				// mostly near the window, sometimes anywhere
				if ($urandom_range(0, 9) == 0) s = 16'($urandom);
				else s = base_seq + 16'($urandom_range(0, 40)) - 16'd4;
				z = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
				send_item(MODE_ADD, s, z);
			end
			if ($urandom_range(0, 5) == 0) base_seq++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		window_credit_we = 1'b0;
		window_credit_wdata = '0;
		in_valid = 1'b0;
		in_item = '0;
		base_seq = 16'd0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty read, in-order, duplicate, gap blocks, beyond window,
		// old sequence, half-distance wrap, extreme sizes, read with nothing to dispatch.
		send_item(MODE_READ, 16'hFFFF, 16'hFFFF);
		send_item(MODE_ADD, 16'd0, 16'd100);
		send_item(MODE_ADD, 16'd0, 16'd100);
		send_item(MODE_ADD, 16'd2, 16'd0);
		send_item(MODE_ADD, 16'd4, 16'd1);
		send_item(MODE_ADD, 16'd34, 16'd1);
		send_item(MODE_ADD, 16'd40, 16'd1);
		send_item(MODE_ADD, 16'h8000, 16'd5);
		send_item(MODE_ADD, 16'd3, 16'hFFFF);
		send_item(MODE_READ, 16'd0, 16'd0);
		send_item(MODE_ADD, 16'd0, 16'd7);
		send_item(MODE_READ, 16'd0, 16'd0);
		for (int k = 5; k < 36; k += 2) send_item(MODE_ADD, 16'(k), 16'd3);
		send_item(MODE_ADD, 16'd1, 16'd2);
		drain_and_idle();

		// No credit at all, then the largest credit value with random traffic.
		write_credit('0);
		send_item(MODE_ADD, 16'd50, 16'd1);
		send_item(MODE_ADD, 16'd36, 16'd0);
		drain_and_idle();
		write_credit(21'h1FFFFF);
		base_seq = 16'd36;
		random_phase(110);
		drain_and_idle();

		// Tight credit with a long receiver hold-off so the block backs up.
		write_credit(21'd1500);
		hold_off = 400;
		random_phase(110);
		drain_and_idle();

		write_credit(CREDIT_RESET);
		base_seq = base_seq + 16'd10;
		random_phase(120);
		drain_and_idle();

		if (fail_count == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
